### rtl/radial_schrodinger_rk4_shooter_core_assert.svh
// Assertion macros for the radial shooter core.
// Used by the top level only; no other dependencies.
`ifndef RADIAL_SCHRODINGER_RK4_SHOOTER_CORE_ASSERT_SVH
`define RADIAL_SCHRODINGER_RK4_SHOOTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RSRK4_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define RSRK4_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/rsrk4_pkg.sv
// Types, codes and micro-program tables for the radial shooter core.
// No dependencies; imported by the top level and the testbench.
`default_nettype none

package rsrk4_pkg;

   // Request and result payloads
   typedef struct packed {
      logic signed [41:0] potential;
      logic               first_sample;
      logic               last_sample;
   } req_type;

   typedef struct packed {
      logic signed [63:0] u_value;
      logic signed [63:0] u_slope;
      logic [16:0]        point_index;
      logic               overshoot;
      logic               diverged;
      logic               run_end;
   } rsp_type;

   // Configuration port
   localparam int CSR_WIDTH       = 41;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [1:0] CSR_AMPLITUDE = 2'd0;
   localparam logic [1:0] CSR_ENERGY    = 2'd1;
   localparam logic [1:0] CSR_STEP      = 2'd2;

   localparam int INDEX_WIDTH = 17;
   localparam logic [16:0] INDEX_MAX = 17'h1FFFF;

   // Shared unit operations
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // Result scaling
   localparam logic [1:0] SH_NONE  = 2'd0;
   localparam logic [1:0] SH_FRAC  = 2'd1;
   localparam logic [1:0] SH_FRAC1 = 2'd2;

   // Operand and destination codes
   localparam logic [4:0] R_ZERO  = 5'd0;
   localparam logic [4:0] R_U     = 5'd1;
   localparam logic [4:0] R_V     = 5'd2;
   localparam logic [4:0] R_PH    = 5'd3;
   localparam logic [4:0] R_PC    = 5'd4;
   localparam logic [4:0] R_E     = 5'd5;
   localparam logic [4:0] R_H     = 5'd6;
   localparam logic [4:0] R_UC    = 5'd7;
   localparam logic [4:0] R_I     = 5'd8;
   localparam logic [4:0] R_I2    = 5'd9;
   localparam logic [4:0] R_I1    = 5'd10;
   localparam logic [4:0] R_TWO   = 5'd11;
   localparam logic [4:0] R_THREE = 5'd12;
   localparam logic [4:0] R_SIX   = 5'd13;
   localparam logic [4:0] R_PHIM  = 5'd14;
   localparam logic [4:0] R_RN0   = 5'd15;
   localparam logic [4:0] R_RNH   = 5'd16;
   localparam logic [4:0] R_RN1   = 5'd17;
   localparam logic [4:0] R_K1V   = 5'd18;
   localparam logic [4:0] R_K2U   = 5'd19;
   localparam logic [4:0] R_K2V   = 5'd20;
   localparam logic [4:0] R_K3U   = 5'd21;
   localparam logic [4:0] R_K3V   = 5'd22;
   localparam logic [4:0] R_K4U   = 5'd23;
   localparam logic [4:0] R_K4V   = 5'd24;
   localparam logic [4:0] R_UM    = 5'd25;
   localparam logic [4:0] R_T1    = 5'd26;
   localparam logic [4:0] R_T2    = 5'd27;
   localparam logic [4:0] R_S     = 5'd28;
   localparam logic [4:0] R_X     = 5'd29;
   localparam logic [4:0] R_SU    = 5'd30;
   localparam logic [4:0] R_NU    = 5'd31;

   typedef struct packed {
      logic [1:0] op;
      logic [4:0] src_a;
      logic [4:0] src_b;
      logic [1:0] shift;
      logic [4:0] dst;
      logic       last;
   } uop_type;

   function automatic uop_type mk(input logic [1:0] op, input logic [4:0] a,
                                  input logic [4:0] b, input logic [1:0] sh,
                                  input logic [4:0] dst, input logic last);
      uop_type r;
      r.op = op; r.src_a = a; r.src_b = b; r.shift = sh; r.dst = dst; r.last = last;
      return r;
   endfunction

   // Series start at the origin: u1 = uc + c*h*h, v1 = 2*c*h
   function automatic uop_type series_uop(input logic [5:0] step);
      uop_type r;
      case (step)
         6'd0:    r = mk(OP_SUB, R_E,    R_PH,    SH_NONE, R_T2, 1'b0);
         6'd1:    r = mk(OP_MUL, R_T2,   R_UC,    SH_FRAC, R_T2, 1'b0);
         6'd2:    r = mk(OP_SUB, R_ZERO, R_T2,    SH_NONE, R_T2, 1'b0);
         6'd3:    r = mk(OP_DIV, R_T2,   R_THREE, SH_NONE, R_T1, 1'b0);
         6'd4:    r = mk(OP_MUL, R_T1,   R_H,     SH_FRAC, R_S,  1'b0);
         6'd5:    r = mk(OP_MUL, R_S,    R_H,     SH_FRAC, R_X,  1'b0);
         6'd6:    r = mk(OP_ADD, R_UC,   R_X,     SH_NONE, R_U,  1'b0);
         default: r = mk(OP_ADD, R_S,    R_S,     SH_NONE, R_V,  1'b1);
      endcase
      return r;
   endfunction

   // One RK4 step from grid point i to i+1
   function automatic uop_type rk4_uop(input logic [5:0] step);
      uop_type r;
      case (step)
         6'd0:  r = mk(OP_MUL, R_I,    R_H,    SH_NONE,  R_RN0,  1'b0);
         6'd1:  r = mk(OP_MUL, R_I2,   R_H,    SH_NONE,  R_RNH,  1'b0);
         6'd2:  r = mk(OP_MUL, R_I1,   R_H,    SH_NONE,  R_RN1,  1'b0);
         6'd3:  r = mk(OP_ADD, R_PH,   R_PC,   SH_NONE,  R_S,    1'b0);
         6'd4:  r = mk(OP_DIV, R_S,    R_TWO,  SH_NONE,  R_PHIM, 1'b0);
         // k1v = accel(u, v, r)
         6'd5:  r = mk(OP_DIV, R_V,    R_RN0,  SH_FRAC,  R_T1,   1'b0);
         6'd6:  r = mk(OP_SUB, R_E,    R_PH,   SH_NONE,  R_T2,   1'b0);
         6'd7:  r = mk(OP_MUL, R_T2,   R_U,    SH_FRAC,  R_T2,   1'b0);
         6'd8:  r = mk(OP_ADD, R_T1,   R_T2,   SH_NONE,  R_S,    1'b0);
         6'd9:  r = mk(OP_ADD, R_S,    R_S,    SH_NONE,  R_S,    1'b0);
         6'd10: r = mk(OP_SUB, R_ZERO, R_S,    SH_NONE,  R_K1V,  1'b0);
         6'd11: r = mk(OP_MUL, R_H,    R_V,    SH_FRAC1, R_X,    1'b0);
         6'd12: r = mk(OP_ADD, R_U,    R_X,    SH_NONE,  R_UM,   1'b0);
         6'd13: r = mk(OP_MUL, R_H,    R_K1V,  SH_FRAC1, R_X,    1'b0);
         6'd14: r = mk(OP_ADD, R_V,    R_X,    SH_NONE,  R_K2U,  1'b0);
         // k2v at the midpoint
         6'd15: r = mk(OP_DIV, R_K2U,  R_RNH,  SH_FRAC1, R_T1,   1'b0);
         6'd16: r = mk(OP_SUB, R_E,    R_PHIM, SH_NONE,  R_T2,   1'b0);
         6'd17: r = mk(OP_MUL, R_T2,   R_UM,   SH_FRAC,  R_T2,   1'b0);
         6'd18: r = mk(OP_ADD, R_T1,   R_T2,   SH_NONE,  R_S,    1'b0);
         6'd19: r = mk(OP_ADD, R_S,    R_S,    SH_NONE,  R_S,    1'b0);
         6'd20: r = mk(OP_SUB, R_ZERO, R_S,    SH_NONE,  R_K2V,  1'b0);
         6'd21: r = mk(OP_MUL, R_H,    R_K2U,  SH_FRAC1, R_X,    1'b0);
         6'd22: r = mk(OP_ADD, R_U,    R_X,    SH_NONE,  R_UM,   1'b0);
         6'd23: r = mk(OP_MUL, R_H,    R_K2V,  SH_FRAC1, R_X,    1'b0);
         6'd24: r = mk(OP_ADD, R_V,    R_X,    SH_NONE,  R_K3U,  1'b0);
         // k3v at the midpoint
         6'd25: r = mk(OP_DIV, R_K3U,  R_RNH,  SH_FRAC1, R_T1,   1'b0);
         6'd26: r = mk(OP_SUB, R_E,    R_PHIM, SH_NONE,  R_T2,   1'b0);
         6'd27: r = mk(OP_MUL, R_T2,   R_UM,   SH_FRAC,  R_T2,   1'b0);
         6'd28: r = mk(OP_ADD, R_T1,   R_T2,   SH_NONE,  R_S,    1'b0);
         6'd29: r = mk(OP_ADD, R_S,    R_S,    SH_NONE,  R_S,    1'b0);
         6'd30: r = mk(OP_SUB, R_ZERO, R_S,    SH_NONE,  R_K3V,  1'b0);
         6'd31: r = mk(OP_MUL, R_H,    R_K3U,  SH_FRAC,  R_X,    1'b0);
         6'd32: r = mk(OP_ADD, R_U,    R_X,    SH_NONE,  R_UM,   1'b0);
         6'd33: r = mk(OP_MUL, R_H,    R_K3V,  SH_FRAC,  R_X,    1'b0);
         6'd34: r = mk(OP_ADD, R_V,    R_X,    SH_NONE,  R_K4U,  1'b0);
         // k4v at the end of the step
         6'd35: r = mk(OP_DIV, R_K4U,  R_RN1,  SH_FRAC,  R_T1,   1'b0);
         6'd36: r = mk(OP_SUB, R_E,    R_PC,   SH_NONE,  R_T2,   1'b0);
         6'd37: r = mk(OP_MUL, R_T2,   R_UM,   SH_FRAC,  R_T2,   1'b0);
         6'd38: r = mk(OP_ADD, R_T1,   R_T2,   SH_NONE,  R_S,    1'b0);
         6'd39: r = mk(OP_ADD, R_S,    R_S,    SH_NONE,  R_S,    1'b0);
         6'd40: r = mk(OP_SUB, R_ZERO, R_S,    SH_NONE,  R_K4V,  1'b0);
         // Weighted sum for u
         6'd41: r = mk(OP_ADD, R_K2U,  R_K2U,  SH_NONE,  R_S,    1'b0);
         6'd42: r = mk(OP_ADD, R_V,    R_S,    SH_NONE,  R_SU,   1'b0);
         6'd43: r = mk(OP_ADD, R_K3U,  R_K3U,  SH_NONE,  R_S,    1'b0);
         6'd44: r = mk(OP_ADD, R_S,    R_K4U,  SH_NONE,  R_S,    1'b0);
         6'd45: r = mk(OP_ADD, R_SU,   R_S,    SH_NONE,  R_SU,   1'b0);
         6'd46: r = mk(OP_MUL, R_H,    R_SU,   SH_FRAC,  R_X,    1'b0);
         6'd47: r = mk(OP_DIV, R_X,    R_SIX,  SH_NONE,  R_X,    1'b0);
         6'd48: r = mk(OP_ADD, R_U,    R_X,    SH_NONE,  R_NU,   1'b0);
         // Weighted sum for u'
         6'd49: r = mk(OP_ADD, R_K2V,  R_K2V,  SH_NONE,  R_S,    1'b0);
         6'd50: r = mk(OP_ADD, R_K1V,  R_S,    SH_NONE,  R_SU,   1'b0);
         6'd51: r = mk(OP_ADD, R_K3V,  R_K3V,  SH_NONE,  R_S,    1'b0);
         6'd52: r = mk(OP_ADD, R_S,    R_K4V,  SH_NONE,  R_S,    1'b0);
         6'd53: r = mk(OP_ADD, R_SU,   R_S,    SH_NONE,  R_SU,   1'b0);
         6'd54: r = mk(OP_MUL, R_H,    R_SU,   SH_FRAC,  R_X,    1'b0);
         6'd55: r = mk(OP_DIV, R_X,    R_SIX,  SH_NONE,  R_X,    1'b0);
         6'd56: r = mk(OP_ADD, R_V,    R_X,    SH_NONE,  R_V,    1'b0);
         default: r = mk(OP_ADD, R_NU, R_ZERO, SH_NONE,  R_U,    1'b1);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/radial_schrodinger_rk4_shooter_core.sv
// Outward RK4 shooter for the radial Schrodinger equation, top level.
// Depends on rsrk4_pkg and radial_schrodinger_rk4_shooter_core_assert.svh.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   rsrk4_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready   rsrk4_pkg::rsp_type
//   csr      in         csr_write_enable      csr_index, csr_data
//
// One shared unit (saturating add/subtract, a 64x64 multiplier built from four
// 32x32 partial products, and a one-bit-per-cycle 128-bit divider for the divisions
// by the radius) runs a micro-program. Halving and the divisions by three and six
// go through the multiplier as rounded reciprocal products.
// An RK4 request sends four divisions by the radius through the divider; first
// or frozen requests skip the micro-program and go straight to the output register.
// Reset is synchronous; req_ready is low while a request is being worked on, and a
// finished result waits in the output register while rsp_ready is low.
`default_nettype none

module radial_schrodinger_rk4_shooter_core #(
   parameter int MAX_POINTS = 131072,
   parameter int FRAC_BITS  = 28
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire rsrk4_pkg::req_type                   req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output rsrk4_pkg::rsp_type                        rsp_data,
   input  wire logic                                 csr_write_enable,
   input  wire logic [rsrk4_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [rsrk4_pkg::CSR_WIDTH-1:0]       csr_data
);
   import rsrk4_pkg::*;

   `include "radial_schrodinger_rk4_shooter_core_assert.svh"

   localparam logic [INDEX_WIDTH-1:0] IDX_CAP =
      ((MAX_POINTS - 1) < int'(INDEX_MAX)) ? INDEX_WIDTH'(MAX_POINTS - 1) : INDEX_MAX;
   localparam logic [127:0] DIV_LIM = 128'd10000000000 << FRAC_BITS;
   localparam logic [6:0] SHAMT_FRAC  = 7'(FRAC_BITS);
   localparam logic [6:0] SHAMT_FRAC1 = 7'(FRAC_BITS + 1);
   localparam logic [63:0] RECIP_THIRD = 64'hAAAA_AAAA_AAAA_AAAB;
   localparam logic [63:0] RECIP_HALF  = 64'h8000_0000_0000_0000;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ISSUE = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_MRND  = 4'd3;
   localparam logic [3:0] ST_DIV   = 4'd4;
   localparam logic [3:0] ST_DRND  = 4'd5;
   localparam logic [3:0] ST_SAT   = 4'd6;
   localparam logic [3:0] ST_POST  = 4'd7;
   localparam logic [3:0] ST_FIN   = 4'd8;

   localparam logic PROG_SERIES = 1'b0;
   localparam logic PROG_RK4    = 1'b1;

   // Configuration registers
   logic [32:0]        amp_cfg_ff;
   logic signed [40:0] energy_ff;
   logic [28:0]        step_ff;

   // Architectural state of the run
   logic [63:0]            amp_ff, slope_ff, prev_pot_ff;
   logic [INDEX_WIDTH-1:0] idx_ff;
   logic                   crossed_ff, blown_ff;

   // Request latch and sequencer
   logic [3:0]  state_ff;
   logic [5:0]  pc_ff;
   logic        prog_ff, first_ff, last_ff;
   logic [63:0] cur_pot_ff;

   // Scratch registers of the micro-program
   logic [63:0] phim_ff, rn0_ff, rnh_ff, rn1_ff, k1v_ff, k2u_ff, k2v_ff;
   logic [63:0] k3u_ff, k3v_ff, k4u_ff, k4v_ff, um_ff, t1_ff, t2_ff, s_ff;
   logic [63:0] x_ff, su_ff, nu_ff;

   // Shared unit registers
   logic [63:0]  am_ff, bm_ff, d_ff, prod_ff, rem_ff;
   logic         neg_ff, nornd_ff;
   logic [6:0]   shamt_ff, dcnt_ff;
   logic [2:0]   mcnt_ff;
   logic [1:0]   pk_ff;
   logic [127:0] acc_ff, nq_ff, qm_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   uop_type     uop;
   logic [63:0] regv [32];
   logic [63:0] a_val, b_val, a_mag, arith_val;
   logic [64:0] arith_wide;
   logic [6:0]  shamt_in;
   logic        wr_en;
   logic [63:0] wr_val, sat_val, sat_mag;
   logic [31:0] a_half, b_half;
   logic [6:0]  pk_off;
   logic [127:0] rnd_add;
   logic [64:0] div_part, div_diff;
   logic        div_ge, rnd_up;
   logic [63:0] au;
   logic        blow, cross_now, req_fire;
   logic        const_div;
   logic [63:0] cdiv_mul, cdiv_bias;
   logic [6:0]  cdiv_shamt;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_fire  = req_valid && req_ready;

   // Current micro-instruction
   assign uop = (prog_ff == PROG_RK4) ? rk4_uop(pc_ff) : series_uop(pc_ff);

   // Operand sources
   always_comb begin
      regv[R_ZERO]  = 64'd0;
      regv[R_U]     = amp_ff;
      regv[R_V]     = slope_ff;
      regv[R_PH]    = prev_pot_ff;
      regv[R_PC]    = cur_pot_ff;
      regv[R_E]     = 64'(energy_ff);
      regv[R_H]     = {35'd0, step_ff};
      regv[R_UC]    = {31'd0, amp_cfg_ff};
      regv[R_I]     = 64'(idx_ff);
      regv[R_I2]    = {46'd0, idx_ff, 1'b1};
      regv[R_I1]    = 64'(idx_ff) + 64'd1;
      regv[R_TWO]   = 64'd2;
      regv[R_THREE] = 64'd3;
      regv[R_SIX]   = 64'd6;
      regv[R_PHIM]  = phim_ff;
      regv[R_RN0]   = rn0_ff;
      regv[R_RNH]   = rnh_ff;
      regv[R_RN1]   = rn1_ff;
      regv[R_K1V]   = k1v_ff;
      regv[R_K2U]   = k2u_ff;
      regv[R_K2V]   = k2v_ff;
      regv[R_K3U]   = k3u_ff;
      regv[R_K3V]   = k3v_ff;
      regv[R_K4U]   = k4u_ff;
      regv[R_K4V]   = k4v_ff;
      regv[R_UM]    = um_ff;
      regv[R_T1]    = t1_ff;
      regv[R_T2]    = t2_ff;
      regv[R_S]     = s_ff;
      regv[R_X]     = x_ff;
      regv[R_SU]    = su_ff;
      regv[R_NU]    = nu_ff;
   end

   assign a_val = regv[uop.src_a];
   assign b_val = regv[uop.src_b];
   assign a_mag = a_val[63] ? (64'd0 - a_val) : a_val;

   always_comb begin
      case (uop.shift)
         SH_FRAC:  shamt_in = SHAMT_FRAC;
         SH_FRAC1: shamt_in = SHAMT_FRAC1;
         default:  shamt_in = 7'd0;
      endcase
   end

   // Division by a small constant: round(m/d) = floor((m + d/2) / d), formed as
   // a product with a reciprocal and a right shift on the multiplier
   always_comb begin
      const_div = (uop.op == OP_DIV) && (uop.src_b inside {R_TWO, R_THREE, R_SIX});
      case (uop.src_b)
         R_TWO: begin
            cdiv_mul   = RECIP_HALF;
            cdiv_bias  = 64'd1;
            cdiv_shamt = 7'd64;
         end
         R_THREE: begin
            cdiv_mul   = RECIP_THIRD;
            cdiv_bias  = 64'd1;
            cdiv_shamt = 7'd65;
         end
         default: begin
            cdiv_mul   = RECIP_THIRD;
            cdiv_bias  = 64'd3;
            cdiv_shamt = 7'd66;
         end
      endcase
   end

   // Saturating add and subtract
   always_comb begin
      if (uop.op == OP_SUB) begin
         arith_wide = {a_val[63], a_val} - {b_val[63], b_val};
      end else begin
         arith_wide = {a_val[63], a_val} + {b_val[63], b_val};
      end
      if (arith_wide[64] != arith_wide[63]) begin
         arith_val = arith_wide[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
         arith_val = arith_wide[63:0];
      end
   end

   // Partial product selection and placement
   assign a_half = mcnt_ff[1] ? am_ff[63:32] : am_ff[31:0];
   assign b_half = mcnt_ff[0] ? bm_ff[63:32] : bm_ff[31:0];
   assign pk_off = {pk_ff[1] & pk_ff[0], pk_ff[1] ^ pk_ff[0], 5'd0};
   assign rnd_add = (shamt_ff == 7'd0 || nornd_ff) ? 128'd0 : (128'd1 << (shamt_ff - 7'd1));

   // Restoring divider step and final rounding
   assign div_part = {rem_ff, nq_ff[127]};
   assign div_ge   = div_part >= {1'b0, d_ff};
   assign div_diff = div_part - {1'b0, d_ff};
   assign rnd_up   = {rem_ff, 1'b0} >= {1'b0, d_ff};

   // Magnitude back to a saturated signed value
   always_comb begin
      sat_mag = (qm_ff[127:64] != 64'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : qm_ff[63:0];
      if (neg_ff) begin
         sat_val = sat_mag[63] ? 64'h8000_0000_0000_0000 : (64'd0 - sat_mag);
      end else begin
         sat_val = sat_mag[63] ? 64'h7FFF_FFFF_FFFF_FFFF : sat_mag;
      end
   end

   // Result write-back from the shared unit
   always_comb begin
      wr_en  = 1'b0;
      wr_val = sat_val;
      if (state_ff == ST_SAT) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_ISSUE) begin
         if (uop.op == OP_ADD || uop.op == OP_SUB) begin
            wr_en  = 1'b1;
            wr_val = arith_val;
         end else if (uop.op == OP_DIV && b_val == 64'd0) begin
            wr_en  = 1'b1;
            wr_val = 64'd0;
         end
      end
   end

   // Divergence test and the overshoot rule for the result
   assign au        = amp_ff[63] ? (64'd0 - amp_ff) : amp_ff;
   assign blow      = (au != 64'd0) && ({64'd0, au - 64'd1} >= DIV_LIM);
   assign cross_now = crossed_ff | (!first_ff && amp_ff[63] && idx_ff != '0);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         amp_cfg_ff <= 33'(64'd1 << FRAC_BITS);
         energy_ff  <= '0;
         step_ff    <= 29'd671089;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_AMPLITUDE: amp_cfg_ff <= csr_data[32:0];
            CSR_ENERGY:    energy_ff  <= csr_data;
            CSR_STEP:      step_ff    <= csr_data[28:0];
            default:       ;
         endcase
      end
   end

   // Sequencer, run state and shared unit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         amp_ff       <= '0;
         slope_ff     <= '0;
         prev_pot_ff  <= '0;
         idx_ff       <= '0;
         crossed_ff   <= 1'b0;
         blown_ff     <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FIN) begin
            rsp_valid_ff <= 1'b0;
         end

         // Register write-back and step advance
         if (wr_en) begin
            case (uop.dst)
               R_U:    amp_ff   <= wr_val;
               R_V:    slope_ff <= wr_val;
               R_PHIM: phim_ff  <= wr_val;
               R_RN0:  rn0_ff   <= wr_val;
               R_RNH:  rnh_ff   <= wr_val;
               R_RN1:  rn1_ff   <= wr_val;
               R_K1V:  k1v_ff   <= wr_val;
               R_K2U:  k2u_ff   <= wr_val;
               R_K2V:  k2v_ff   <= wr_val;
               R_K3U:  k3u_ff   <= wr_val;
               R_K3V:  k3v_ff   <= wr_val;
               R_K4U:  k4u_ff   <= wr_val;
               R_K4V:  k4v_ff   <= wr_val;
               R_UM:   um_ff    <= wr_val;
               R_T1:   t1_ff    <= wr_val;
               R_T2:   t2_ff    <= wr_val;
               R_S:    s_ff     <= wr_val;
               R_X:    x_ff     <= wr_val;
               R_SU:   su_ff    <= wr_val;
               R_NU:   nu_ff    <= wr_val;
               default: ;
            endcase
            if (uop.last) begin
               state_ff <= ST_POST;
            end else begin
               pc_ff    <= pc_ff + 6'd1;
               state_ff <= ST_ISSUE;
            end
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  first_ff   <= req_data.first_sample;
                  last_ff    <= req_data.last_sample;
                  cur_pot_ff <= 64'(req_data.potential);
                  pc_ff      <= '0;
                  prog_ff    <= (idx_ff == '0) ? PROG_SERIES : PROG_RK4;
                  if (req_data.first_sample) begin
                     // A new run starts at the origin
                     amp_ff      <= {31'd0, amp_cfg_ff};
                     slope_ff    <= '0;
                     prev_pot_ff <= 64'(req_data.potential);
                     idx_ff      <= '0;
                     crossed_ff  <= 1'b0;
                     blown_ff    <= 1'b0;
                     state_ff    <= ST_FIN;
                  end else if (!blown_ff && idx_ff < IDX_CAP) begin
                     state_ff <= ST_ISSUE;
                  end else begin
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_ISSUE: begin
               neg_ff   <= (uop.op == OP_DIV) ? a_val[63] : (a_val[63] ^ b_val[63]);
               am_ff    <= const_div ? (a_mag + cdiv_bias) : a_mag;
               if (const_div) begin
                  bm_ff <= cdiv_mul;
               end else begin
                  bm_ff <= b_val[63] ? (64'd0 - b_val) : b_val;
               end
               d_ff     <= b_val;
               shamt_ff <= const_div ? cdiv_shamt : shamt_in;
               nornd_ff <= const_div;
               acc_ff   <= '0;
               mcnt_ff  <= '0;
               dcnt_ff  <= '0;
               rem_ff   <= '0;
               nq_ff    <= 128'(a_mag) << shamt_in;
               if (uop.op == OP_MUL || const_div) begin
                  state_ff <= ST_MUL;
               end else if (uop.op == OP_DIV && b_val != 64'd0) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_MUL: begin
               // Four partial products, each registered before accumulation
               if (mcnt_ff != 3'd4) begin
                  prod_ff <= 64'(a_half) * 64'(b_half);
                  pk_ff   <= mcnt_ff[1:0];
               end
               if (mcnt_ff != 3'd0) begin
                  acc_ff <= acc_ff + (128'(prod_ff) << pk_off);
               end
               if (mcnt_ff == 3'd4) begin
                  state_ff <= ST_MRND;
               end else begin
                  mcnt_ff <= mcnt_ff + 3'd1;
               end
            end
            ST_MRND: begin
               qm_ff    <= (acc_ff + rnd_add) >> shamt_ff;
               state_ff <= ST_SAT;
            end
            ST_DIV: begin
               rem_ff  <= div_ge ? div_diff[63:0] : div_part[63:0];
               nq_ff   <= {nq_ff[126:0], div_ge};
               dcnt_ff <= dcnt_ff + 7'd1;
               if (dcnt_ff == 7'd127) begin
                  state_ff <= ST_DRND;
               end
            end
            ST_DRND: begin
               qm_ff    <= nq_ff + 128'(rnd_up);
               state_ff <= ST_SAT;
            end
            ST_SAT: begin
               // The write-back above stores the result and moves on
            end
            ST_POST: begin
               // Advance the grid point and update the sticky flags
               idx_ff      <= idx_ff + 17'd1;
               prev_pot_ff <= cur_pot_ff;
               if (amp_ff[63]) begin
                  crossed_ff <= 1'b1;
               end
               if (blow) begin
                  blown_ff <= 1'b1;
               end
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  crossed_ff               <= cross_now;
                  rsp_data_ff.u_value      <= amp_ff;
                  rsp_data_ff.u_slope      <= slope_ff;
                  rsp_data_ff.point_index  <= idx_ff;
                  rsp_data_ff.overshoot    <= cross_now;
                  rsp_data_ff.diverged     <= blown_ff;
                  rsp_data_ff.run_end      <= last_ff;
                  rsp_valid_ff             <= 1'b1;
                  state_ff                 <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Checks on the run state
   `RSRK4_ASSERT_NEXT(frozen_run_holds, req_fire && !req_data.first_sample && blown_ff, $stable(amp_ff))
   `RSRK4_ASSERT_IMPL(index_within_cap, 1'b1, idx_ff <= IDX_CAP)
   `RSRK4_ASSERT_NEXT(overshoot_sticky, crossed_ff && !(req_fire && req_data.first_sample), crossed_ff)

endmodule

`default_nettype wire

### sim/tb_radial_schrodinger_rk4_shooter_core.sv
// Self-checking testbench for the radial Schrodinger RK4 shooter core.
// Depends on rsrk4_pkg and radial_schrodinger_rk4_shooter_core; has its own fixed-point predictor.
`timescale 1ns / 1ps
`default_nettype none

class shooter_scoreboard;
   typedef logic signed [63:0] fx_type;

   // Mirror of the configuration registers
   fx_type amplitude, energy, spacing;
   // Mirror of the integrator state
   fx_type u_held, v_held, phi_prev;
   logic [16:0] index_held;
   logic crossed, blown;

   rsrk4_pkg::rsp_type expected_points[$];
   int results_seen, mismatches, runs_started, runs_diverged;

   function new();
      amplitude = 64'sd1 <<< 28;
      energy = 0;
      spacing = 64'sd671089;
      u_held = 0; v_held = 0; phi_prev = 0;
      index_held = 0; crossed = 0; blown = 0;
      results_seen = 0; mismatches = 0; runs_started = 0; runs_diverged = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [40:0] val);
      case (idx)
         rsrk4_pkg::CSR_AMPLITUDE: amplitude = {31'b0, val[32:0]};
         rsrk4_pkg::CSR_ENERGY:    energy = {{23{val[40]}}, val[40:0]};
         rsrk4_pkg::CSR_STEP:      spacing = {35'b0, val[28:0]};
         default: ;
      endcase
   endfunction

   function logic [63:0] magnitude(fx_type a);
      return a[63] ? (~a + 64'd1) : a;
   endfunction

   function fx_type signed_of(logic [63:0] m, logic neg);
      if (neg) return (m >= 64'h8000000000000000) ? 64'sh8000000000000000 : -$signed(m);
      return (m > 64'h7FFFFFFFFFFFFFFF) ? 64'sh7FFFFFFFFFFFFFFF : $signed(m);
   endfunction

   function fx_type clamp65(logic signed [64:0] s);
      if (s > 65'sh07FFFFFFFFFFFFFFF) return 64'sh7FFFFFFFFFFFFFFF;
      if (s < -65'sh08000000000000000) return 64'sh8000000000000000;
      return s[63:0];
   endfunction

   function fx_type sat_add(fx_type a, fx_type b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      return clamp65(s);
   endfunction

   function fx_type sat_sub(fx_type a, fx_type b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      return clamp65(s);
   endfunction

   // Rounded a*b / 2^s, ties away from zero, saturating
   function fx_type mul_round(fx_type a, fx_type b, int s);
      logic [127:0] p;
      logic [63:0] m;
      p = {64'b0, magnitude(a)} * {64'b0, magnitude(b)};
      p = (p + (128'd1 << (s - 1))) >> s;
      m = (p[127:64] != 0) ? '1 : p[63:0];
      return signed_of(m, a[63] != b[63]);
   endfunction

   // Rounded a * 2^s / d; a zero divisor gives zero
   function fx_type div_round(fx_type a, logic [63:0] d, int s);
      logic [127:0] n, q, r;
      logic [63:0] m;
      if (d == 0) return 0;
      n = {64'b0, magnitude(a)} << s;
      q = n / {64'b0, d};
      r = n % {64'b0, d};
      if (r[63:0] >= d - r[63:0]) q = q + 1;
      m = (q[127:64] != 0) ? '1 : q[63:0];
      return signed_of(m, a[63]);
   endfunction

   // u'' = -2v/r - 2(E - phi)u with r = rnum / 2^(28+rs)
   function fx_type curvature(fx_type u, fx_type v, logic [63:0] rnum, int rs, fx_type phi);
      fx_type t1, t2, s;
      t1 = div_round(v, rnum, 28 + rs);
      t2 = mul_round(sat_sub(energy, phi), u, 28);
      s = sat_add(t1, t2);
      return sat_sub(0, sat_add(s, s));
   endfunction

   function void series_start();
      fx_type c, ch;
      c = div_round(sat_sub(0, mul_round(sat_sub(energy, phi_prev), amplitude, 28)), 64'd3, 0);
      ch = mul_round(c, spacing, 28);
      u_held = sat_add(amplitude, mul_round(ch, spacing, 28));
      v_held = sat_add(ch, ch);
   endfunction

   function void rk4_advance(fx_type phi_cur);
      logic [63:0] i, h;
      fx_type u, v, phi_mid, k1v, k2u, k2v, k3u, k3v, k4u, k4v, um, su, sv;
      i = {47'b0, index_held};
      h = spacing;
      u = u_held; v = v_held;
      phi_mid = div_round(sat_add(phi_prev, phi_cur), 64'd2, 0);
      k1v = curvature(u, v, i * h, 0, phi_prev);
      um = sat_add(u, mul_round(spacing, v, 29));
      k2u = sat_add(v, mul_round(spacing, k1v, 29));
      k2v = curvature(um, k2u, (2 * i + 1) * h, 1, phi_mid);
      um = sat_add(u, mul_round(spacing, k2u, 29));
      k3u = sat_add(v, mul_round(spacing, k2v, 29));
      k3v = curvature(um, k3u, (2 * i + 1) * h, 1, phi_mid);
      um = sat_add(u, mul_round(spacing, k3u, 28));
      k4u = sat_add(v, mul_round(spacing, k3v, 28));
      k4v = curvature(um, k4u, (i + 1) * h, 0, phi_cur);
      su = sat_add(sat_add(v, sat_add(k2u, k2u)), sat_add(sat_add(k3u, k3u), k4u));
      sv = sat_add(sat_add(k1v, sat_add(k2v, k2v)), sat_add(sat_add(k3v, k3v), k4v));
      u_held = sat_add(u, div_round(mul_round(spacing, su, 28), 64'd6, 0));
      v_held = sat_add(v, div_round(mul_round(spacing, sv, 28), 64'd6, 0));
   endfunction

   // Accepted request: advance the mirrored integrator and queue the expected point.
   function void note_request(rsrk4_pkg::req_type r);
      fx_type phi;
      logic [63:0] au;
      rsrk4_pkg::rsp_type e;
      phi = r.potential;
      if (r.first_sample) begin
         u_held = amplitude; v_held = 0; phi_prev = phi;
         index_held = 0; crossed = 0; blown = 0;
         runs_started++;
      end else if (!blown && index_held < rsrk4_pkg::INDEX_MAX) begin
         if (index_held == 0) series_start();
         else rk4_advance(phi);
         index_held++;
         phi_prev = phi;
         if (u_held < 0) crossed = 1;
         au = magnitude(u_held);
         if (au != 0 && ((au - 1) >> 28) >= 64'd10000000000) begin
            blown = 1;
            runs_diverged++;
         end
      end
      if (!r.first_sample && u_held < 0 && index_held >= 1) crossed = 1;
      e.u_value = u_held;
      e.u_slope = v_held;
      e.point_index = index_held;
      e.overshoot = crossed;
      e.diverged = blown;
      e.run_end = r.last_sample;
      expected_points.push_back(e);
   endfunction

   function void check_result(rsrk4_pkg::rsp_type got);
      rsrk4_pkg::rsp_type e;
      results_seen++;
      if (expected_points.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
         return;
      end
      e = expected_points.pop_front();
      if (got.u_value !== e.u_value || got.u_slope !== e.u_slope ||
          got.point_index !== e.point_index || got.overshoot !== e.overshoot ||
          got.diverged !== e.diverged || got.run_end !== e.run_end) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("ERROR: result %0d mismatch", results_seen);
            $display("  u     exp %0d got %0d", e.u_value, got.u_value);
            $display("  du    exp %0d got %0d", e.u_slope, got.u_slope);
            $display("  index exp %0d got %0d", e.point_index, got.point_index);
            $display("  flags exp cross=%b div=%b end=%b got cross=%b div=%b end=%b",
                     e.overshoot, e.diverged, e.run_end,
                     got.overshoot, got.diverged, got.run_end);
         end
      end
   endfunction
endclass

module tb_radial_schrodinger_rk4_shooter_core;
   import rsrk4_pkg::*;

   localparam int STALL_LIMIT = 40000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_data;
   logic csr_write_enable = 0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_WIDTH-1:0] csr_data = '0;

   shooter_scoreboard sb = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int requests_taken = 0;
   int quiet_cycles = 0;

   radial_schrodinger_rk4_shooter_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // Receiver back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Monitor both channels and watch for a hung block.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_request(req_data);
            requests_taken++;
         end
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [40:0] val);
      @(negedge clock);
      csr_write_enable = 1;
      csr_index = idx;
      csr_data = val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_write_enable = 0;
   endtask

   // Present one request, with a random gap first, and hold it until taken.
   task automatic send_sample(logic signed [41:0] phi, logic first, logic last);
      int taken;
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         req_valid = 0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      taken = requests_taken;
      req_valid = 1;
      req_data.potential = phi;
      req_data.first_sample = first;
      req_data.last_sample = last;
      while (requests_taken == taken) @(negedge clock);
   endtask

   // Mostly gentle potentials, sometimes anywhere in the legal range.
   function automatic logic signed [41:0] draw_potential();
      logic [40:0] raw;
      if ($urandom_range(9) < 7) return 42'(signed'($urandom)) >>> $urandom_range(6);
      raw = 41'({$urandom, $urandom});
      return {raw[40], raw};
   endfunction

   task automatic drain();
      req_valid = 0;
      while (sb.expected_points.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic random_runs(int count);
      int sent, len;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(12, 1);
         // An occasional run continues the previous one without a first sample.
         if ($urandom_range(7) != 0 || sent == 0) begin
            send_sample(draw_potential(), 1, 0);
            sent++;
         end
         for (int k = 0; k < len; k++) begin
            send_sample(draw_potential(), $urandom_range(19) == 0, k == len - 1);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: defaults first, with a sample that starts no run.
      send_sample(42'sd1 <<< 28, 0, 0);
      send_sample(-(42'sd1 <<< 28), 0, 1);
      send_sample(42'sd1 <<< 40, 1, 0);
      send_sample(-(42'sd1 <<< 40), 0, 0);
      send_sample(42'sd0, 0, 1);
      send_sample(42'sd3 <<< 27, 0, 0);
      send_sample(-(42'sd1 <<< 40), 1, 0);
      send_sample(42'sd1 <<< 40, 0, 0);
      send_sample(42'sd0, 0, 0);
      drain();
      // Extreme settings: amplitude 2^32, most negative energy, unit step.
      write_csr(CSR_AMPLITUDE, 41'h1_0000_0000);
      write_csr(CSR_ENERGY, 41'h100_0000_0000);
      write_csr(CSR_STEP, 41'h1000_0000);
      send_sample(42'sd0, 1, 0);
      for (int k = 0; k < 6; k++) send_sample(42'sd0, 0, k == 5);
      send_sample(42'sd1 <<< 40, 0, 0);
      drain();
      // Other extremes: no amplitude, zero energy, smallest nonzero step.
      write_csr(CSR_AMPLITUDE, 41'd0);
      write_csr(CSR_ENERGY, 41'd0);
      write_csr(CSR_STEP, 41'd1);
      send_sample(42'sd5 <<< 28, 1, 0);
      send_sample(-(42'sd5 <<< 28), 0, 0);
      send_sample(42'sd2 <<< 28, 0, 1);
      drain();

      // Random phases with different idling and settings.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 46; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 16; stall_pct = 16; end
         endcase
         write_csr(CSR_AMPLITUDE, $urandom_range(3) == 0 ? 41'h1_0000_0000
                                                        : 41'($urandom_range(32'h4000_0000)));
         write_csr(CSR_ENERGY, -41'($urandom_range(32'h8000_0000)) <<< $urandom_range(8));
         write_csr(CSR_STEP, $urandom_range(3) == 0 ? 41'h1000_0000
                                                    : 41'($urandom_range(32'h0400_0000, 1)));
         random_runs(110);
         drain();
      end
      stall_pct = 0;
      repeat (20) @(posedge clock);

      $display("Checked %0d results over %0d runs, %0d of which diverged.",
               sb.results_seen, sb.runs_started, sb.runs_diverged);
      $display("Mismatches: %0d, results still awaited: %0d.",
               sb.mismatches, sb.expected_points.size());
      if (sb.mismatches == 0 && sb.expected_points.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

`default_nettype wire
